/* src/assert_macros.svh */
// assertion helpers included by the decoder unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/utd_pkg.sv */
`default_nettype none
package utd_pkg;

  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;

  localparam logic [UNIT_W-1:0] SURR_MASK  = 16'hFC00;
  localparam logic [UNIT_W-1:0] HIGH_BASE  = 16'hD800;
  localparam logic [UNIT_W-1:0] LOW_BASE   = 16'hDC00;
  localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;
  localparam logic [CP_W-1:0]   CTRL_LIMIT = 21'h00020;
  localparam logic [CP_W-1:0]   SURR_CP_MASK = 21'h1FF800;
  localparam logic [CP_W-1:0]   SURR_CP_BASE = 21'h00D800;
  localparam logic [CP_W-1:0]   CP_CR      = 21'd13;
  localparam logic [CP_W-1:0]   CP_BS      = 21'd8;

  // configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_INJECTION_ENABLE = 3'd0;

  typedef enum logic [1:0] {
    CMD_FEED       = 2'd0,
    CMD_ACTIVATE   = 2'd1,
    CMD_DEACTIVATE = 2'd2,
    CMD_SWALLOW    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              active;
    logic [UNIT_W-1:0] pending_high;
    logic              swallow;
  } state_t;

  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] code_point;
    logic            from_pair;
  } result_t;

endpackage
`default_nettype wire

/* src/utf16_text_input_decoder_unit.sv */
`default_nettype none
// UTF-16 text input decoder: takes one command per request (feed a code unit,
// activate, deactivate, swallow the next unit) and emits at most one decoded
// code point per request, joining a high and a low surrogate into one
// supplementary value. It sustains one request per clock unless the result
// channel stalls; a request passes an input register and one decode stage
// into the result register, which offers its code point on the result channel.
// Requests that yield no code point still update the decoder state in order.
// The single register injection_enable sits at byte address 0 and should be
// written only while the block is idle.
`include "assert_macros.svh"
module utf16_text_input_decoder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_command,
  input  wire logic [utd_pkg::UNIT_W-1:0]        in_code_unit,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [utd_pkg::CP_W-1:0]               out_code_point,
  output logic                                   out_from_pair,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [utd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic                          s1_valid_r;
  utd_pkg::cmd_t                 s1_cmd_r;
  logic [utd_pkg::UNIT_W-1:0]    s1_unit_r;
  utd_pkg::state_t               st_r;
  utd_pkg::state_t               st_nxt;
  utd_pkg::result_t              res;
  logic                          out_valid_r;
  logic [utd_pkg::CP_W-1:0]      out_code_point_r;
  logic                          out_from_pair_r;
  logic                          enable_r;
  logic                          in_acc;
  logic                          s1_adv;
  logic                          cfg_wr;

  // handshake
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign s1_adv   = s1_valid_r && !(out_valid_r && out_stall);

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == utd_pkg::ADDR_INJECTION_ENABLE);
  assign prdata = (paddr == utd_pkg::ADDR_INJECTION_ENABLE) ? {31'd0, enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr) begin
      enable_r <= pwdata[0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= utd_pkg::cmd_t'(in_command);
      s1_unit_r <= in_code_unit;
    end
  end

  // decode stage
  utd_decode u_decode (
    .cmd    (s1_cmd_r),
    .unit   (s1_unit_r),
    .enable (enable_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      out_code_point_r <= res.code_point;
      out_from_pair_r  <= res.from_pair;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;
  assign out_from_pair  = out_from_pair_r;

  // checks
  `ASSERT_IMP(a_pair_supp, clk, rst_n, out_valid_r && out_from_pair_r,
              out_code_point_r >= utd_pkg::SUPP_BASE, "pair result below supplementary range")
  `ASSERT_IMP(a_single_bmp, clk, rst_n, out_valid_r && !out_from_pair_r,
              out_code_point_r[utd_pkg::CP_W-1:utd_pkg::UNIT_W] == '0,
              "single unit result outside basic plane")
  `ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r,
              "input stalled with a free stage")
  `ASSERT_NXT(a_deact_clear, clk, rst_n,
              s1_adv && s1_cmd_r == utd_pkg::CMD_DEACTIVATE,
              !st_r.active && !st_r.swallow && st_r.pending_high == '0,
              "deactivate left state behind")

endmodule
`default_nettype wire

/* src/utd_decode.sv */
`default_nettype none
module utd_decode (
  input  wire utd_pkg::cmd_t                 cmd,
  input  wire logic [utd_pkg::UNIT_W-1:0]    unit,
  input  wire logic                          enable,
  input  wire utd_pkg::state_t               st,
  output utd_pkg::state_t                    st_nxt,
  output utd_pkg::result_t                   res
);

  logic                       is_high;
  logic                       is_low;
  logic                       pair;
  logic [utd_pkg::CP_W-1:0]   combined;
  logic [utd_pkg::CP_W-1:0]   cp;
  logic                       cp_ok;

  // surrogate classification and pair combination
  assign is_high  = (unit & utd_pkg::SURR_MASK) == utd_pkg::HIGH_BASE;
  assign is_low   = (unit & utd_pkg::SURR_MASK) == utd_pkg::LOW_BASE;
  assign pair     = is_low && (st.pending_high != '0);
  assign combined = {1'b0, st.pending_high[9:0], unit[9:0]} + utd_pkg::SUPP_BASE;
  assign cp       = pair ? combined : {5'd0, unit};

  // filter: no stray controls, no surrogates, injection enabled
  assign cp_ok = enable
              && !(cp < utd_pkg::CTRL_LIMIT && cp != utd_pkg::CP_CR && cp != utd_pkg::CP_BS)
              && ((cp & utd_pkg::SURR_CP_MASK) != utd_pkg::SURR_CP_BASE);

  // command handling and state update
  always_comb begin
    st_nxt         = st;
    res.valid      = 1'b0;
    res.code_point = cp;
    res.from_pair  = pair;
    unique case (cmd)
      utd_pkg::CMD_ACTIVATE: begin
        st_nxt.active       = 1'b1;
        st_nxt.pending_high = '0;
      end
      utd_pkg::CMD_DEACTIVATE: begin
        st_nxt.active       = 1'b0;
        st_nxt.pending_high = '0;
        st_nxt.swallow      = 1'b0;
      end
      utd_pkg::CMD_SWALLOW: begin
        st_nxt.swallow = 1'b1;
      end
      utd_pkg::CMD_FEED: begin
        priority if (!st.active) begin
          st_nxt.pending_high = '0;
        end else if (st.swallow) begin
          st_nxt.swallow = 1'b0;
        end else if (is_high) begin
          st_nxt.pending_high = unit;
        end else begin
          st_nxt.pending_high = '0;
          res.valid           = cp_ok;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule
`default_nettype wire

/* verif/utf16_text_input_decoder_unit_tb.sv */
`timescale 1ns / 1ps

// one decoded code point the block should emit
typedef struct {
  logic [utd_pkg::CP_W-1:0] cp;
  logic                     pair;
} decoded_point_t;

// tracks decoder state and holds the code points still owed by the block
class code_point_board;
  bit                          enable_on;
  bit                          active;
  logic [utd_pkg::UNIT_W-1:0]  pending_high;
  bit                          swallow;
  decoded_point_t              points_due[$];
  int                          errors;

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  // advance the decoder state for one accepted request
  function void note_request(utd_pkg::cmd_t cmd, logic [utd_pkg::UNIT_W-1:0] unit);
    logic [utd_pkg::CP_W-1:0] cp;
    logic                     pair;
    decoded_point_t           dp;
    pair = 1'b0;
    case (cmd)
      utd_pkg::CMD_ACTIVATE: begin
        active = 1'b1;
        pending_high = '0;
        return;
      end
      utd_pkg::CMD_DEACTIVATE: begin
        active = 1'b0;
        pending_high = '0;
        swallow = 1'b0;
        return;
      end
      utd_pkg::CMD_SWALLOW: begin
        swallow = 1'b1;
        return;
      end
      default: ;
    endcase
    // feed: inactive, swallowed and high-surrogate units give nothing
    if (!active) begin
      pending_high = '0;
      return;
    end
    if (swallow) begin
      swallow = 1'b0;
      return;
    end
    if ((unit & utd_pkg::SURR_MASK) == utd_pkg::HIGH_BASE) begin
      pending_high = unit;
      return;
    end
    cp = {5'd0, unit};
    if ((unit & utd_pkg::SURR_MASK) == utd_pkg::LOW_BASE && pending_high != '0) begin
      cp = {1'b0, pending_high[9:0], unit[9:0]} + utd_pkg::SUPP_BASE;
      pair = 1'b1;
    end
    pending_high = '0;
    // filter controls, stray surrogates and disabled injection
    if (cp < utd_pkg::CTRL_LIMIT && cp != utd_pkg::CP_CR && cp != utd_pkg::CP_BS) return;
    if ((cp & utd_pkg::SURR_CP_MASK) == utd_pkg::SURR_CP_BASE) return;
    if (!enable_on) return;
    dp.cp = cp;
    dp.pair = pair;
    points_due.push_back(dp);
  endfunction

  // compare one emitted code point with the oldest one owed
  function void check_point(logic [utd_pkg::CP_W-1:0] cp, logic pair);
    decoded_point_t dp;
    if (points_due.size() == 0) begin
      flag($sformatf("unexpected code point %h pair %b", cp, pair));
      return;
    end
    dp = points_due.pop_front();
    if (cp !== dp.cp)
      flag($sformatf("code_point expected %h actual %h", dp.cp, cp));
    if (pair !== dp.pair)
      flag($sformatf("from_pair expected %b actual %b (cp %h)", dp.pair, pair, dp.cp));
  endfunction
endclass

module utf16_text_input_decoder_unit_tb;

  localparam int LIMIT      = 200000;
  localparam int UNIT_W     = utd_pkg::UNIT_W;
  localparam int CP_W       = utd_pkg::CP_W;
  localparam int CFG_ADDR_W = utd_pkg::CFG_ADDR_W;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_command;
  logic [UNIT_W-1:0]     in_code_unit;
  logic                  out_valid;
  logic                  out_stall;
  logic [CP_W-1:0]       out_code_point;
  logic                  out_from_pair;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  code_point_board sb;
  bit              calm;
  int              cycles;

  utf16_text_input_decoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_code_unit(in_code_unit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_point(out_code_point), .out_from_pair(out_from_pair),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("utf16_text_input_decoder_unit test failed");
      $finish;
    end
  end

  // result side: check taken code points, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_point(out_code_point, out_from_pair);
    out_stall <= !calm && ($urandom_range(0, 99) < 13);
  end

  // one request, with optional idle cycles before it
  task automatic send_request(utd_pkg::cmd_t cmd, logic [UNIT_W-1:0] unit);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_code_unit <= unit;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, unit);
  endtask

  task automatic feed(logic [UNIT_W-1:0] unit);
    send_request(utd_pkg::CMD_FEED, unit);
  endtask

  // stop requests and wait for the pipeline to empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write: setup then access
  task automatic write_enable(bit val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= utd_pkg::ADDR_INJECTION_ENABLE;
    pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.enable_on = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly well-formed text with some noise and broken pairs
  task automatic random_text(int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (!sb.active && pick < 70) begin
        send_request(utd_pkg::CMD_ACTIVATE, UNIT_W'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 4) begin
        send_request(utd_pkg::CMD_DEACTIVATE, UNIT_W'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 8) begin
        send_request(utd_pkg::CMD_SWALLOW, UNIT_W'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 11) begin
        send_request(utd_pkg::CMD_ACTIVATE, UNIT_W'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 36) begin
        feed(utd_pkg::HIGH_BASE | UNIT_W'($urandom_range(0, 1023)));
        feed(utd_pkg::LOW_BASE | UNIT_W'($urandom_range(0, 1023)));
        sent++;
      end else if (pick < 44) begin
        feed(utd_pkg::HIGH_BASE | UNIT_W'($urandom_range(0, 1023)));
      end else if (pick < 52) begin
        feed(utd_pkg::LOW_BASE | UNIT_W'($urandom_range(0, 1023)));
      end else if (pick < 62) begin
        feed(UNIT_W'($urandom_range(0, 31)));
      end else begin
        feed(UNIT_W'($urandom_range(0, 16'hFFFF)));
      end
      sent++;
    end
  endtask

  initial begin
    sb = new;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= utd_pkg::CMD_FEED;
    in_code_unit <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_enable(1'b1);

    // directed: inactive feed, controls, extremes, pairs, lone halves, swallow
    feed(16'h0041);
    send_request(utd_pkg::CMD_ACTIVATE, 16'hFFFF);
    feed(16'h0000);
    feed(16'h0008);
    feed(16'h000D);
    feed(16'h001F);
    feed(16'h0020);
    feed(16'hFFFF);
    feed(16'hD800);
    feed(16'hDC00);
    feed(16'hDBFF);
    feed(16'hDFFF);
    feed(16'hDC00);
    feed(16'hD83D);
    feed(16'h0041);
    feed(16'hD801);
    feed(16'hD83D);
    feed(16'hDE00);
    send_request(utd_pkg::CMD_SWALLOW, 16'h0000);
    feed(16'h0042);
    feed(16'hD83C);
    send_request(utd_pkg::CMD_SWALLOW, 16'h0000);
    feed(16'h0043);
    feed(16'hDF89);
    send_request(utd_pkg::CMD_DEACTIVATE, 16'h0000);
    send_request(utd_pkg::CMD_SWALLOW, 16'h0000);
    send_request(utd_pkg::CMD_ACTIVATE, 16'h0000);
    feed(16'h0044);
    feed(16'h0045);
    drain();

    random_text(330);
    drain();

    // injection disabled: nothing may come out
    write_enable(1'b0);
    random_text(150);
    drain();

    write_enable(1'b1);
    random_text(80);
    calm = 1'b1;
    random_text(60);
    calm = 1'b0;
    random_text(80);
    drain();

    if (sb.errors == 0 && sb.points_due.size() == 0) begin
      $display("utf16_text_input_decoder_unit test passed");
    end else begin
      $display("utf16_text_input_decoder_unit test failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/utd_pkg.sv
src/utd_decode.sv
src/utf16_text_input_decoder_unit.sv
verif/utf16_text_input_decoder_unit_tb.sv
